/* rtl/ctbc_pkg.sv */
// ----------------------------------------------------------------------------
// ctbc_pkg - shared types for the complete binary tree checker
// Child index width, memory tag width, child pair layout and sequencer states.
// ----------------------------------------------------------------------------
package ctbc_pkg;

   localparam int CHILD_W = 11;   // width of a child index on the request port
   localparam int GEN_W   = 8;    // tree generation tag kept in the parent map

   typedef logic [CHILD_W-1:0] child_type;

   typedef struct packed {
      child_type left;
      child_type right;
   } child_pair_type;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_MARK_R   = 12'b0000_0000_0100,
      ST_FIN      = 12'b0000_0000_1000,
      ST_SCAN_RD  = 12'b0000_0001_0000,
      ST_SCAN_CHK = 12'b0000_0010_0000,
      ST_W_INIT   = 12'b0000_0100_0000,
      ST_W_RD     = 12'b0000_1000_0000,
      ST_W_CHK    = 12'b0001_0000_0000,
      ST_W_TBL    = 12'b0010_0000_0000,
      ST_W_PUSHR  = 12'b0100_0000_0000,
      ST_UNUSED   = 12'b1000_0000_0000
   } state_type;

endpackage

/* rtl/complete_binary_tree_check_top.sv */
// ----------------------------------------------------------------------------
// complete_binary_tree_check_top - complete binary tree checker
// Loads a tree one node per transaction, then finds the root and walks the
// tree in level order to decide whether it is complete.
// ----------------------------------------------------------------------------
// Usage: each accepted transaction (start high while busy is low) loads one
// node, numbered from 1 in arrival order, with its left and right child index
// (0 = none). A node loads as a table write plus left mark, then a right mark,
// and busy is high while the right mark is made. After the node flagged
// last_node, the checker runs its finish sequence on one shared compare/count
// datapath under a small sequencer: an index check, a scan for the root (one
// parent map read per node scanned), and a level-order walk (queue read, table
// read and two queue pushes per node visited). One result then shows on rsp_*
// with rsp_valid high for exactly one cycle; the receiver cannot stall it.
// Parent marks carry a tree generation tag, so no clearing is needed between
// trees, except that every 255 trees, and once after reset, the parent map is
// swept one entry a cycle, entries 0 to MAX_NODES, with busy held high.
// ----------------------------------------------------------------------------
module complete_binary_tree_check_top #(
   parameter int MAX_NODES   = 1024,
   parameter int QUEUE_SLOTS = 2050
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [ctbc_pkg::CHILD_W-1:0] req_left_index,
   input  logic [ctbc_pkg::CHILD_W-1:0] req_right_index,
   input  logic                      req_last_node,
   output logic                      rsp_valid,
   output logic                      rsp_is_complete,
   output logic                      rsp_index_error
);

   // count width, table address, parent map address, queue address/count
   localparam int CW  = $clog2(MAX_NODES + 1);
   localparam int TAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int HW  = $clog2(MAX_NODES + 1);
   localparam int QAW = $clog2(QUEUE_SLOTS);
   localparam int QCW = $clog2(QUEUE_SLOTS + 1);
   localparam int QW  = (CW > ctbc_pkg::CHILD_W) ? CW : ctbc_pkg::CHILD_W;
   localparam int TW  = 2 * ctbc_pkg::CHILD_W;

   // sequencer and counters
   ctbc_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   ctbc_pkg::child_type       max_child_ff, max_child_in;
   logic [ctbc_pkg::GEN_W-1:0] gen_ff, gen_in;
   logic [HW-1:0]             clr_idx_ff, clr_idx_in;
   logic [CW-1:0]             scan_idx_ff, scan_idx_in;
   logic [QCW-1:0]            head_ff, head_in;
   logic [QCW-1:0]            tail_ff, tail_in;
   logic [QCW-1:0]            nz_ff, nz_in;     // nonzero entries still queued
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      stored_ff, stored_in;

   // payload
   ctbc_pkg::child_type       right_ff, right_in;
   logic                      last_ff, last_in;
   logic [QW-1:0]             root_ff, root_in;
   logic                      complete_ff, complete_in;
   logic                      error_ff, error_in;

   // memory ports
   logic                      tbl_we, tbl_re;
   logic [TAW-1:0]            tbl_waddr, tbl_raddr;
   ctbc_pkg::child_pair_type  tbl_wdata, tbl_rdata;
   logic [TW-1:0]             tbl_rdata_raw;
   logic                      hp_we, hp_re;
   logic [HW-1:0]             hp_waddr, hp_raddr;
   logic [ctbc_pkg::GEN_W-1:0] hp_wdata, hp_rdata;
   logic                      q_we, q_re;
   logic [QAW-1:0]            q_waddr, q_raddr;
   logic [QW-1:0]             q_wdata, q_rdata;

   logic                      accept;

   assign busy    = (state_ff != ctbc_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign tbl_rdata = ctbc_pkg::child_pair_type'(tbl_rdata_raw);

   // left and right child tables, one row per loaded node
   ctbc_ram #(.DEPTH(MAX_NODES), .WIDTH(TW), .AW(TAW)) u_node_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (TW'(tbl_wdata)),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata_raw)
   );

   // parent map: an entry equal to the current generation means "has parent"
   ctbc_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(ctbc_pkg::GEN_W), .AW(HW)) u_parent_map (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_waddr),
      .wr_data (hp_wdata),
      .rd_en   (hp_re),
      .rd_addr (hp_raddr),
      .rd_data (hp_rdata)
   );

   // level-order walk queue
   ctbc_ram #(.DEPTH(QUEUE_SLOTS), .WIDTH(QW), .AW(QAW)) u_walk_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   always_comb begin
      logic                do_finish;
      logic                fin_complete;
      logic                fin_error;
      logic                left_ok;
      logic                right_ok;
      logic                stored;
      ctbc_pkg::child_type max1;

      do_finish    = 1'b0;
      fin_complete = 1'b0;
      fin_error    = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      max_child_in = max_child_ff;
      gen_in       = gen_ff;
      clr_idx_in   = clr_idx_ff;
      scan_idx_in  = scan_idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      nz_in        = nz_ff;
      rsp_valid_in = 1'b0;
      stored_in    = stored_ff;
      right_in     = right_ff;
      last_in      = last_ff;
      root_in      = root_ff;
      complete_in  = complete_ff;
      error_in     = error_ff;

      tbl_we    = 1'b0;
      tbl_waddr = TAW'(count_ff);
      tbl_wdata = '{left: req_left_index, right: req_right_index};
      tbl_re    = 1'b0;
      tbl_raddr = TAW'(q_rdata - QW'(1));
      hp_we     = 1'b0;
      hp_waddr  = HW'(req_left_index);
      hp_wdata  = gen_ff;
      hp_re     = 1'b0;
      hp_raddr  = HW'(scan_idx_ff);
      q_we      = 1'b0;
      q_waddr   = QAW'(tail_ff);
      q_wdata   = QW'(tbl_rdata.left);
      q_re      = 1'b0;
      q_raddr   = QAW'(head_ff);

      // marks only name nodes 1..MAX_NODES
      left_ok  = (req_left_index != '0) &&
                 (32'(req_left_index) <= 32'(MAX_NODES));
      right_ok = (right_ff != '0) && (32'(right_ff) <= 32'(MAX_NODES));
      stored   = (32'(count_ff) < 32'(MAX_NODES));
      max1     = (req_left_index > max_child_ff) ? req_left_index : max_child_ff;

      unique case (state_ff)
         ctbc_pkg::ST_CLEAR: begin
            hp_we    = 1'b1;
            hp_waddr = clr_idx_ff;
            hp_wdata = '0;
            if (clr_idx_ff == HW'(MAX_NODES)) begin
               gen_in   = ctbc_pkg::GEN_W'(1);
               state_in = ctbc_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + HW'(1);
            end
         end
         ctbc_pkg::ST_IDLE: begin
            if (accept) begin
               stored_in = stored;
               right_in  = req_right_index;
               last_in   = req_last_node;
               state_in  = ctbc_pkg::ST_MARK_R;
               if (stored) begin
                  tbl_we       = 1'b1;
                  hp_we        = left_ok;
                  count_in     = count_ff + CW'(1);
                  max_child_in = (req_right_index > max1) ? req_right_index : max1;
               end
            end
         end
         ctbc_pkg::ST_MARK_R: begin
            hp_we    = stored_ff && right_ok;
            hp_waddr = HW'(right_ff);
            state_in = last_ff ? ctbc_pkg::ST_FIN : ctbc_pkg::ST_IDLE;
         end
         ctbc_pkg::ST_FIN: begin
            if (32'(max_child_ff) > 32'(count_ff)) begin
               do_finish = 1'b1;
               fin_error = 1'b1;
            end else if (count_ff == '0) begin
               do_finish    = 1'b1;
               fin_complete = 1'b1;
            end else begin
               scan_idx_in = CW'(1);
               state_in    = ctbc_pkg::ST_SCAN_RD;
            end
         end
         ctbc_pkg::ST_SCAN_RD: begin
            hp_re    = 1'b1;
            state_in = ctbc_pkg::ST_SCAN_CHK;
         end
         ctbc_pkg::ST_SCAN_CHK: begin
            if (hp_rdata != gen_ff) begin
               root_in  = QW'(scan_idx_ff);
               state_in = ctbc_pkg::ST_W_INIT;
            end else if (scan_idx_ff == count_ff) begin
               // every node has a parent: no root
               do_finish    = 1'b1;
               fin_complete = 1'b1;
            end else begin
               scan_idx_in = scan_idx_ff + CW'(1);
               state_in    = ctbc_pkg::ST_SCAN_RD;
            end
         end
         ctbc_pkg::ST_W_INIT: begin
            q_we     = 1'b1;
            q_waddr  = '0;
            q_wdata  = root_ff;
            head_in  = '0;
            tail_in  = QCW'(1);
            nz_in    = QCW'(1);
            state_in = ctbc_pkg::ST_W_RD;
         end
         ctbc_pkg::ST_W_RD: begin
            if (head_ff == tail_ff) begin
               do_finish    = 1'b1;
               fin_complete = 1'b1;
            end else begin
               q_re     = 1'b1;
               state_in = ctbc_pkg::ST_W_CHK;
            end
         end
         ctbc_pkg::ST_W_CHK: begin
            head_in = head_ff + QCW'(1);
            if (q_rdata == '0) begin
               // first empty slot: complete only if nothing nonzero follows
               do_finish    = 1'b1;
               fin_complete = (nz_ff == '0);
            end else if ((32'(tail_ff) + 32'd2) > 32'(QUEUE_SLOTS)) begin
               do_finish = 1'b1;   // queue overflow, not a tree
            end else begin
               nz_in    = nz_ff - QCW'(1);
               tbl_re   = 1'b1;
               state_in = ctbc_pkg::ST_W_TBL;
            end
         end
         ctbc_pkg::ST_W_TBL: begin
            q_we     = 1'b1;
            tail_in  = tail_ff + QCW'(1);
            nz_in    = nz_ff + QCW'(tbl_rdata.left != '0);
            state_in = ctbc_pkg::ST_W_PUSHR;
         end
         ctbc_pkg::ST_W_PUSHR: begin
            q_we     = 1'b1;
            q_wdata  = QW'(tbl_rdata.right);
            tail_in  = tail_ff + QCW'(1);
            nz_in    = nz_ff + QCW'(tbl_rdata.right != '0);
            state_in = ctbc_pkg::ST_W_RD;
         end
         default: begin
            state_in = ctbc_pkg::ST_IDLE;
         end
      endcase

      // post the result and start a fresh tree generation
      if (do_finish) begin
         rsp_valid_in = 1'b1;
         complete_in  = fin_complete;
         error_in     = fin_error;
         count_in     = '0;
         max_child_in = '0;
         gen_in       = gen_ff + ctbc_pkg::GEN_W'(1);
         if (gen_ff == {ctbc_pkg::GEN_W{1'b1}}) begin
            clr_idx_in = '0;
            state_in   = ctbc_pkg::ST_CLEAR;
         end else begin
            state_in = ctbc_pkg::ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctbc_pkg::ST_CLEAR;
         count_ff     <= '0;
         max_child_ff <= '0;
         gen_ff       <= '0;
         clr_idx_ff   <= '0;
         scan_idx_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         stored_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_child_ff <= max_child_in;
         gen_ff       <= gen_in;
         clr_idx_ff   <= clr_idx_in;
         scan_idx_ff  <= scan_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
         stored_ff    <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff    <= right_in;
      last_ff     <= last_in;
      root_ff     <= root_in;
      complete_ff <= complete_in;
      error_ff    <= error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_complete = complete_ff;
   assign rsp_index_error = error_ff;

endmodule

/* rtl/ctbc_ram.sv */
// ----------------------------------------------------------------------------
// ctbc_ram - simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module ctbc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 22,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
